// ----- rtl/fifo_block_cache_hit_counter_macros.svh -----
// Assertion macros used by the block's top-level RTL file.
`ifndef FIFO_BLOCK_CACHE_HIT_COUNTER_MACROS_SVH
`define FIFO_BLOCK_CACHE_HIT_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
`define FBCHC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("fbchc assertion failed");
`define FBCHC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("fbchc forbidden condition seen");
`else
`define FBCHC_ASSERT(lbl, clk, rst_n, prop)
`define FBCHC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- rtl/fbchc_pkg.sv -----
`timescale 1ns / 1ps

package fbchc_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int ADDR_WIDTH   = 64;
    localparam int IN_ADDR_W    = 64;
    localparam int CNT_W        = 48;
    localparam int CAP_W        = 7;
    localparam int OCC_W        = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_RESET    = 50;

    typedef logic [ADDR_WIDTH-1:0] t_addr;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [OCC_W-1:0]      t_occ;

    typedef struct packed {
        logic  shift;
        t_addr key;
    } t_cell_ctl;

endpackage

// ----- rtl/fifo_block_cache_hit_counter.sv -----
// Fully associative FIFO cache of basic-block addresses with hit, miss and block counters.
// Input channel: i_in_valid / o_in_stall with i_block_address; one transaction per address.
// Output channel: o_out_valid / i_out_stall with the hit flag, the three saturating 48-bit
// counts and the occupancy after the transaction.
// Configuration: pulse i_cfg_wr_en with i_cfg_wr_data to set the capacity, only while idle.
// The write empties the store; the counts are kept. Capacities above 64 behave as 64.
// The address is registered on acceptance, then compared against the 64 cells in parallel
// once the output can take the result; that step also shifts the chain of cells, updates
// the counts and registers the result. Throughput is one transaction per cycle while the
// output does not stall.
// While the output stalls, the finished result is held and one further address may wait in
// the input register; o_in_stall rises once both are occupied.
// Reset clears the counters, the fill level and both valid flags; the capacity becomes 50.
`timescale 1ns / 1ps
`include "fifo_block_cache_hit_counter_macros.svh"

module fifo_block_cache_hit_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fbchc_pkg::CAP_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fbchc_pkg::IN_ADDR_W-1:0] i_block_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [fbchc_pkg::CNT_W-1:0]   o_blocks_seen,
    output logic [fbchc_pkg::CNT_W-1:0]   o_hits_seen,
    output logic [fbchc_pkg::CNT_W-1:0]   o_misses_seen,
    output logic [fbchc_pkg::CAP_W-1:0]   o_occupancy
);
    import fbchc_pkg::*;

    logic              r_in_vld;
    t_addr             r_addr;
    logic [CAP_W-1:0]  r_cap;
    t_occ              r_fill;
    t_occ              n_fill;
    logic              r_out_vld;
    logic              r_hit;
    t_count            r_blocks;
    t_count            r_hits;
    t_count            r_misses;
    t_occ              r_occ;

    logic              accept_in;
    logic              process;
    logic              hit;
    t_occ              cap_eff;
    t_occ              held;
    t_cell_ctl         cell_ctl;
    t_addr             cell_addr [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;
    logic [MAX_ENTRIES-1:0] cell_live;
    t_count            blocks_next;
    t_count            hits_next;
    t_count            misses_next;
    t_count            blocks_cur;
    t_count            hits_cur;
    t_count            misses_cur;

    assign process    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !process;
    assign accept_in  = i_in_valid && !o_in_stall;

    assign cap_eff = (r_cap > CAP_W'(MAX_ENTRIES)) ? t_occ'(MAX_ENTRIES) : t_occ'(r_cap);
    assign held    = (r_fill > cap_eff) ? cap_eff : r_fill;

    assign hit            = |(cell_match & cell_live);
    assign cell_ctl.key   = r_addr;
    assign cell_ctl.shift = process && !hit && (cap_eff != '0);

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign cell_live[g] = (($clog2(MAX_ENTRIES + 1) + 1)'(g) < {1'b0, held});
        fbchc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_prev_addr ((g == 0) ? r_addr : cell_addr[(g == 0) ? 0 : g - 1]),
            .o_addr      (cell_addr[g]),
            .o_match     (cell_match[g])
        );
    end

    always_comb begin
        n_fill = held;
        if (!hit) begin
            if (cap_eff == '0) begin
                n_fill = '0;
            end else if (held < cap_eff) begin
                n_fill = held + t_occ'(1);
            end else begin
                n_fill = cap_eff;
            end
        end
    end

    fbchc_sat_counter u_blocks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (process),
        .o_count (blocks_cur),
        .o_next  (blocks_next)
    );

    fbchc_sat_counter u_hits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (process && hit),
        .o_count (hits_cur),
        .o_next  (hits_next)
    );

    fbchc_sat_counter u_misses (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (process && !hit),
        .o_count (misses_cur),
        .o_next  (misses_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cap     <= CAP_W'(CAP_RESET);
            r_fill    <= '0;
        end else begin
            if (accept_in) begin
                r_in_vld <= 1'b1;
            end else if (process) begin
                r_in_vld <= 1'b0;
            end
            if (process) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_cap  <= i_cfg_wr_data;
                r_fill <= '0;
            end else if (process) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_addr <= i_block_address[ADDR_WIDTH-1:0];
        end
        if (process) begin
            r_hit    <= hit;
            r_blocks <= blocks_next;
            r_hits   <= hits_next;
            r_misses <= misses_next;
            r_occ    <= n_fill;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_hit         = r_hit;
    assign o_blocks_seen = r_blocks;
    assign o_hits_seen   = r_hits;
    assign o_misses_seen = r_misses;
    assign o_occupancy   = CAP_W'(r_occ);

    `FBCHC_ASSERT_NEVER(a_fill_within_cap, i_clk, i_rst_n, r_fill > cap_eff)
    `FBCHC_ASSERT(a_miss_inserts_newest, i_clk, i_rst_n,
        cell_ctl.shift |=> (cell_addr[0] == $past(r_addr)))
    `FBCHC_ASSERT(a_result_from_process, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(process))
    `FBCHC_ASSERT(a_counts_add_up, i_clk, i_rst_n,
        (blocks_cur != {CNT_W{1'b1}}) |->
        ((CNT_W + 1)'(blocks_cur) == (CNT_W + 1)'(hits_cur) + (CNT_W + 1)'(misses_cur)))

endmodule

// ----- rtl/fbchc_cell.sv -----
`timescale 1ns / 1ps

module fbchc_cell (
    input  logic               i_clk,
    input  fbchc_pkg::t_cell_ctl i_ctl,
    input  fbchc_pkg::t_addr   i_prev_addr,
    output fbchc_pkg::t_addr   o_addr,
    output logic               o_match
);
    import fbchc_pkg::*;

    t_addr r_entry;
    t_addr n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_prev_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_addr  = r_entry;
    assign o_match = (r_entry == i_ctl.key);

endmodule

// ----- rtl/fbchc_sat_counter.sv -----
`timescale 1ns / 1ps

module fbchc_sat_counter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_inc,
    output fbchc_pkg::t_count   o_count,
    output fbchc_pkg::t_count   o_next
);
    import fbchc_pkg::*;

    t_count r_count;
    t_count n_count;

    always_comb begin
        n_count = r_count;
        if (i_inc && (r_count != {CNT_W{1'b1}})) begin
            n_count = r_count + t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_next  = n_count;

endmodule
